### rtl/core/metropolis_anneal_accept_defines.svh
// ----------------------------------------------------------------------------
// Metropolis acceptance engine: assertion macros
// Shared property shapes for the checker of the acceptance engine.
// ----------------------------------------------------------------------------
`ifndef METROPOLIS_ANNEAL_ACCEPT_DEFINES_SVH
`define METROPOLIS_ANNEAL_ACCEPT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MAA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MAA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/maa_pkg.sv
// ----------------------------------------------------------------------------
// maa_pkg
// Constants, codes and tables shared by the Metropolis acceptance engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package maa_pkg;

  // Fixed-point format of energies and temperatures
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned PROB_BITS_DEF   = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned TEMP_BITS = 32;
  localparam int unsigned STEP_BITS = 31;
  localparam int unsigned RND_BITS  = 16;

  // Ratio delta/T in Q16, limited below 32.0
  localparam int unsigned X_FRAC    = 16;
  localparam int unsigned X_BITS    = 21;
  localparam int unsigned OVF_SHIFT = X_BITS - X_FRAC;

  // Range reduction by ln 2
  localparam int unsigned N_BITS = 6;
  localparam int unsigned R_BITS = 16;
  localparam int unsigned L_BITS = 17;
  localparam logic [L_BITS-1:0] LN2_Q16 = 17'd45426;

  // Horner evaluation of exp(-r) in Q30
  localparam int unsigned Q30_FRAC     = 30;
  localparam int unsigned ACC_BITS     = 31;
  localparam int unsigned HORNER_TERMS = 8;
  localparam int unsigned K_BITS       = 4;
  localparam int unsigned RECIP_SHIFT  = 33;
  localparam int unsigned RECIP_BITS   = 33;
  localparam logic [ACC_BITS-1:0] Q30_ONE = 31'h4000_0000;

  // Reset and special values
  localparam logic signed [TEMP_BITS-1:0] START_TEMP_RST = 32'sd6554;
  localparam logic signed [TEMP_BITS-1:0] TEMP_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [TEMP_BITS-1:0] TEMP_MIN = {1'b1, 31'b0};
  localparam logic [63:0] LOWEST_RAW = 64'd1000000 << FRAC_BITS;
  localparam logic signed [TEMP_BITS-1:0] LOWEST_INIT =
    (LOWEST_RAW > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : LOWEST_RAW[31:0];

  // Input codes
  localparam logic       MODE_START = 1'b0;
  localparam logic [1:0] MS_MADE    = 2'd0;
  localparam logic [1:0] MS_ERROR   = 2'd2;

  // Decision codes
  localparam logic [2:0] DEC_REJECT   = 3'd0;
  localparam logic [2:0] DEC_DOWNHILL = 3'd1;
  localparam logic [2:0] DEC_UPHILL   = 3'd2;
  localparam logic [2:0] DEC_SKIP     = 3'd3;
  localparam logic [2:0] DEC_IDLE     = 3'd4;

  // Register indexes
  localparam logic REG_START_TEMP = 1'b0;
  localparam logic REG_COOL_STEP  = 1'b1;

  // ceil(2^33 / k): exact floor(p / k) for p < 2^30 after a shift by 33
  function automatic logic [RECIP_BITS-1:0] horner_recip(input logic [K_BITS-1:0] k);
    logic [RECIP_BITS-1:0] m;
    unique case (k)
      4'd2:    m = 33'd4294967296;
      4'd3:    m = 33'd2863311531;
      4'd4:    m = 33'd2147483648;
      4'd5:    m = 33'd1717986919;
      4'd6:    m = 33'd1431655766;
      4'd7:    m = 33'd1227133514;
      4'd8:    m = 33'd1073741824;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/maa_serdiv.sv
// ----------------------------------------------------------------------------
// maa_serdiv
// Restoring divider, one quotient bit per cycle. The dividend bits are shifted
// in MSB first from a shift register that collects the quotient at its tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maa_serdiv #(
  parameter int unsigned QW = maa_pkg::X_BITS,
  parameter int unsigned RW = maa_pkg::TEMP_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] rem_init_i,  // upper dividend part, below the divisor
  input  logic [QW-1:0] bits_i,      // lower dividend bits
  input  logic [RW-1:0] divisor_i,   // held stable while busy
  output logic          done_o,
  output logic [QW-1:0] quot_o,
  output logic [RW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] sh_q;
  logic [RW-1:0] trial;
  logic          ge;

  // Partial remainder with the next dividend bit appended
  assign trial = {rem_q[RW-2:0], sh_q[QW-1]};
  assign ge    = trial >= divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
        rem_q  <= rem_init_i;
        sh_q   <= bits_i;
      end else if (busy_q) begin
        rem_q <= ge ? (trial - divisor_i) : trial;
        sh_q  <= {sh_q[QW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/maa_expo.sv
// ----------------------------------------------------------------------------
// maa_expo
// exp(-r) in Q30 by an eight-term Horner scheme on one shared multiply and
// reciprocal-divide step: each term runs a multiply phase, then a divide phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maa_expo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [maa_pkg::R_BITS-1:0]       r_i,     // reduced ratio, Q16, below ln 2
  output logic                             done_o,
  output logic [maa_pkg::ACC_BITS-1:0]     acc_o    // exp(-r), Q30
);

  localparam int unsigned PW = maa_pkg::R_BITS + maa_pkg::ACC_BITS;
  localparam int unsigned MW = maa_pkg::Q30_FRAC + maa_pkg::RECIP_BITS;

  typedef enum logic {
    PH_MUL,
    PH_DIV
  } phase_e;

  phase_e                           phase_q;
  logic                             busy_q;
  logic                             done_q;
  logic [maa_pkg::K_BITS-1:0]       k_q;
  logic [maa_pkg::R_BITS-1:0]       r_q;
  logic [maa_pkg::ACC_BITS-1:0]     acc_q;
  logic [PW-1:0]                    prod_q;

  logic [PW-1:0]                    prod_d;
  logic [maa_pkg::Q30_FRAC-1:0]     p;
  logic [MW-1:0]                    m;
  logic [maa_pkg::Q30_FRAC-1:0]     q;
  logic [maa_pkg::ACC_BITS-1:0]     acc_d;

  // r * acc; dropping 16 bits gives (r << 14) * acc >> 30
  assign prod_d = PW'(r_q) * PW'(acc_q);
  assign p      = prod_q[maa_pkg::R_BITS +: maa_pkg::Q30_FRAC];

  // Divide by k through its reciprocal, k = 1 passes straight
  assign m     = MW'(p) * MW'(maa_pkg::horner_recip(k_q));
  assign q     = (k_q == maa_pkg::K_BITS'(1)) ? p
                                               : m[maa_pkg::RECIP_SHIFT +: maa_pkg::Q30_FRAC];
  assign acc_d = maa_pkg::Q30_ONE - maa_pkg::ACC_BITS'(q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MUL;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      k_q     <= '0;
      r_q     <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= PH_MUL;
        k_q     <= maa_pkg::K_BITS'(maa_pkg::HORNER_TERMS);
        r_q     <= r_i;
        acc_q   <= maa_pkg::Q30_ONE;
      end else if (busy_q) begin
        unique case (phase_q)
          PH_MUL: begin
            prod_q  <= prod_d;
            phase_q <= PH_DIV;
          end
          PH_DIV: begin
            acc_q   <= acc_d;
            phase_q <= PH_MUL;
            if (k_q == maa_pkg::K_BITS'(1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              k_q <= k_q - maa_pkg::K_BITS'(1);
            end
          end
          default: phase_q <= PH_MUL;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

### rtl/core/metropolis_anneal_accept.sv
// ----------------------------------------------------------------------------
// metropolis_anneal_accept
// Metropolis acceptance engine for simulated annealing with linear cooling.
// Input items (valid/ready) are either a start, which loads start_temp and
// arms the run, or a trial, which on an armed run cools the temperature by
// cool_step and judges one move from its two energies and a random fraction.
// Each item yields exactly one result on the output channel (valid/ready).
// Starts, skips and aborts go from the input straight to the result state;
// downhill keeps and far-uphill rejects pass through the evaluate state. An
// uphill move that needs the exponential runs in turn through the bit-serial
// delta/T divider, the ln 2 reduction and the Horner unit; one item is in
// flight at a time, so the next item is taken once the last has its result.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is accepted and worked on, and that item waits in its
// final state until the register frees. Configuration writes take effect at
// once. Reset clears the counters, loads the lowest energy with 1000000
// saturated to 0x7FFFFFFF and leaves the run disarmed until the first start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module metropolis_anneal_accept #(
  parameter int unsigned PROB_BITS   = maa_pkg::PROB_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = maa_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] old_energy_i,
  input  logic signed [31:0] new_energy_i,
  input  logic [15:0]        random_fraction_i,
  input  logic [1:0]         move_status_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         decision_o,
  output logic               new_lowest_o,
  output logic signed [31:0] temperature_now_o,
  output logic signed [31:0] lowest_energy_o,
  output logic [31:0]        downhill_keeps_o,
  output logic [31:0]        uphill_keeps_o
);

  localparam int unsigned TW     = maa_pkg::TEMP_BITS;
  localparam int unsigned CMP_W  = PROB_BITS + maa_pkg::RND_BITS + 1;
  localparam int unsigned SH_W   = 7;
  localparam int unsigned PSHIFT = maa_pkg::Q30_FRAC - PROB_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SPLIT,
    ST_EXP,
    ST_RESULT
  } state_e;

  // Configuration registers
  logic signed [TW-1:0]             start_temp_q;
  logic [maa_pkg::STEP_BITS-1:0]    cool_step_q;

  // Engine state
  state_e                           state_q;
  logic signed [TW-1:0]             temp_q;
  logic signed [TW-1:0]             lowest_q;
  logic [COUNT_WIDTH-1:0]           dn_cnt_q;
  logic [COUNT_WIDTH-1:0]           up_cnt_q;
  logic                             first_q;
  logic                             active_q;

  // Trial operands and pending result
  logic signed [TW:0]               delta_q;
  logic signed [TW-1:0]             new_e_q;
  logic [maa_pkg::RND_BITS-1:0]     rnd_q;
  logic [maa_pkg::N_BITS-1:0]       n_q;
  logic [2:0]                       res_dec_q;
  logic                             res_newlow_q;

  // Output register
  logic                             out_valid_q;
  logic [2:0]                       dec_out_q;
  logic                             newlow_out_q;
  logic signed [TW-1:0]             temp_out_q;
  logic signed [TW-1:0]             low_out_q;
  logic [31:0]                      dn_out_q;
  logic [31:0]                      up_out_q;

  // Datapath
  logic signed [TW:0]               cooled_w;
  logic signed [TW-1:0]             cooled;
  logic signed [TW:0]               delta_w;
  logic                             delta_pos;
  logic                             dq_pos;
  logic                             ovf;
  logic                             div1_start;
  logic                             div1_done;
  logic [maa_pkg::X_BITS-1:0]       x;
  logic                             div2_start;
  logic                             div2_done;
  logic [maa_pkg::N_BITS-1:0]       n_w;
  logic [maa_pkg::L_BITS-1:0]       rem2;
  logic                             exp_start;
  logic                             exp_done;
  logic [maa_pkg::ACC_BITS-1:0]     exp_acc;
  logic [SH_W-1:0]                  amt;
  logic [maa_pkg::ACC_BITS-1:0]     prob_full;
  logic [CMP_W-1:0]                 lhs;
  logic [CMP_W-1:0]                 rhs;
  logic                             up_pass;
  logic                             keep_dn;
  logic                             keep_up;
  logic                             newlow;
  logic                             out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Cooling step, saturating at the most negative value
  assign cooled_w = {temp_q[TW-1], temp_q} - {2'b00, cool_step_q};
  assign cooled   = (cooled_w[TW] && !cooled_w[TW-1]) ? maa_pkg::TEMP_MIN
                                                       : cooled_w[TW-1:0];

  // Energy change of the move
  assign delta_w   = {new_energy_i[TW-1], new_energy_i} - {old_energy_i[TW-1], old_energy_i};
  assign delta_pos = !delta_w[TW] && (delta_w[TW-1:0] != '0);
  assign dq_pos    = !delta_q[TW] && (delta_q[TW-1:0] != '0);

  // delta/T reaches 32.0 exactly when delta >= 32 * T
  assign ovf = {{maa_pkg::OVF_SHIFT{1'b0}}, delta_q[TW-1:0]}
               >= {temp_q, {maa_pkg::OVF_SHIFT{1'b0}}};

  assign div1_start = (state_q == ST_EVAL) && dq_pos && !ovf;
  assign div2_start = (state_q == ST_DIV) && div1_done;
  assign exp_start  = (state_q == ST_SPLIT) && div2_done;

  // x = floor(delta * 2^16 / T)
  maa_serdiv #(
    .QW (maa_pkg::X_BITS),
    .RW (TW)
  ) u_div_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div1_start),
    .rem_init_i ({{maa_pkg::OVF_SHIFT{1'b0}}, delta_q[TW-1:maa_pkg::OVF_SHIFT]}),
    .bits_i     ({delta_q[maa_pkg::OVF_SHIFT-1:0], {maa_pkg::X_FRAC{1'b0}}}),
    .divisor_i  (temp_q),
    .done_o     (div1_done),
    .quot_o     (x),
    .rem_o      ()
  );

  // n = floor(x / ln 2), r = x - n * ln 2
  maa_serdiv #(
    .QW (maa_pkg::N_BITS),
    .RW (maa_pkg::L_BITS)
  ) u_div_ln2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div2_start),
    .rem_init_i (maa_pkg::L_BITS'(x[maa_pkg::X_BITS-1:maa_pkg::N_BITS])),
    .bits_i     (x[maa_pkg::N_BITS-1:0]),
    .divisor_i  (maa_pkg::LN2_Q16),
    .done_o     (div2_done),
    .quot_o     (n_w),
    .rem_o      (rem2)
  );

  maa_expo u_expo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .r_i     (rem2[maa_pkg::R_BITS-1:0]),
    .done_o  (exp_done),
    .acc_o   (exp_acc)
  );

  // Probability by 2^-n, then the random compare
  assign amt       = SH_W'(PSHIFT) + SH_W'(n_q);
  assign prob_full = exp_acc >> amt;
  assign lhs       = CMP_W'(rnd_q) << PROB_BITS;
  assign rhs       = CMP_W'(prob_full[PROB_BITS:0]) << maa_pkg::RND_BITS;
  assign up_pass   = lhs < rhs;

  // Keep bookkeeping
  assign keep_dn = (state_q == ST_EVAL) && !dq_pos;
  assign keep_up = (state_q == ST_EXP) && exp_done && up_pass;
  assign newlow  = (keep_dn || keep_up) && (new_e_q < lowest_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_temp_q <= maa_pkg::START_TEMP_RST;
      cool_step_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        maa_pkg::REG_START_TEMP: start_temp_q <= cfg_wdata_i;
        maa_pkg::REG_COOL_STEP:  cool_step_q  <= cfg_wdata_i[maa_pkg::STEP_BITS-1:0];
        default:                 cool_step_q  <= cool_step_q;
      endcase
    end
  end

  // Sequencer, engine state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      temp_q       <= '0;
      lowest_q     <= maa_pkg::LOWEST_INIT;
      dn_cnt_q     <= '0;
      up_cnt_q     <= '0;
      first_q      <= 1'b1;
      active_q     <= 1'b0;
      delta_q      <= '0;
      new_e_q      <= '0;
      rnd_q        <= '0;
      n_q          <= '0;
      res_dec_q    <= maa_pkg::DEC_IDLE;
      res_newlow_q <= 1'b0;
      out_valid_q  <= 1'b0;
      dec_out_q    <= maa_pkg::DEC_IDLE;
      newlow_out_q <= 1'b0;
      temp_out_q   <= '0;
      low_out_q    <= '0;
      dn_out_q     <= '0;
      up_out_q     <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            new_e_q      <= new_energy_i;
            rnd_q        <= random_fraction_i;
            delta_q      <= delta_w;
            res_newlow_q <= 1'b0;
            res_dec_q    <= maa_pkg::DEC_IDLE;
            state_q      <= ST_RESULT;
            if (mode_i == maa_pkg::MODE_START) begin
              temp_q   <= start_temp_q;
              active_q <= 1'b1;
              if (first_q) begin
                dn_cnt_q <= '0;
                up_cnt_q <= '0;
                lowest_q <= maa_pkg::LOWEST_INIT;
                first_q  <= 1'b0;
              end
            end else if (active_q) begin
              temp_q <= cooled;
              unique case (move_status_i)
                maa_pkg::MS_MADE: begin
                  res_dec_q <= maa_pkg::DEC_REJECT;
                  state_q   <= ST_EVAL;
                  // non-positive temperature on an uphill move becomes 1.0
                  if (delta_pos && (cooled[TW-1] || (cooled == '0))) begin
                    temp_q <= maa_pkg::TEMP_ONE;
                  end
                end
                maa_pkg::MS_ERROR: active_q  <= 1'b0;
                default:           res_dec_q <= maa_pkg::DEC_SKIP;
              endcase
            end
          end
        end

        ST_EVAL: begin
          if (!dq_pos) begin
            res_dec_q <= maa_pkg::DEC_DOWNHILL;
            state_q   <= ST_RESULT;
          end else if (ovf) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div1_done) begin
            state_q <= ST_SPLIT;
          end
        end

        ST_SPLIT: begin
          if (div2_done) begin
            n_q     <= n_w;
            state_q <= ST_EXP;
          end
        end

        ST_EXP: begin
          if (exp_done) begin
            if (up_pass) begin
              res_dec_q <= maa_pkg::DEC_UPHILL;
            end
            state_q <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            dec_out_q    <= res_dec_q;
            newlow_out_q <= res_newlow_q;
            temp_out_q   <= temp_q;
            low_out_q    <= lowest_q;
            dn_out_q     <= 32'(dn_cnt_q);
            up_out_q     <= 32'(up_cnt_q);
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase

      // Kept move: minimum tracking and keep counters
      if (newlow) begin
        lowest_q     <= new_e_q;
        res_newlow_q <= 1'b1;
      end
      if (keep_dn) begin
        dn_cnt_q <= dn_cnt_q + COUNT_WIDTH'(1);
      end
      if (keep_up) begin
        up_cnt_q <= up_cnt_q + COUNT_WIDTH'(1);
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign decision_o        = dec_out_q;
  assign new_lowest_o      = newlow_out_q;
  assign temperature_now_o = temp_out_q;
  assign lowest_energy_o   = low_out_q;
  assign downhill_keeps_o  = dn_out_q;
  assign uphill_keeps_o    = up_out_q;

endmodule

### rtl/core/maa_checker.sv
// ----------------------------------------------------------------------------
// maa_checker
// Port-level checks on the results of the Metropolis acceptance engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "metropolis_anneal_accept_defines.svh"

module maa_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [2:0]         decision_o,
  input  logic               new_lowest_o,
  input  logic signed [31:0] temperature_now_o,
  input  logic signed [31:0] lowest_energy_o
);

  // A new minimum is only ever reported with a keep
  `MAA_ASSERT_IMP(a_newlow_keep, clk_i, rst_ni, out_valid_o && new_lowest_o, decision_o == maa_pkg::DEC_DOWNHILL || decision_o == maa_pkg::DEC_UPHILL, "new minimum flagged on a transaction that is not a keep")

  // The exponential test runs on a positive temperature only
  `MAA_ASSERT_IMP(a_uphill_temp, clk_i, rst_ni, out_valid_o && decision_o == maa_pkg::DEC_UPHILL, temperature_now_o > 32'sd0, "uphill keep shown with a non-positive temperature")

  // Decision stays within its defined codes
  `MAA_ASSERT_IMP(a_dec_range, clk_i, rst_ni, out_valid_o, decision_o <= maa_pkg::DEC_IDLE, "undefined decision code on a result transaction")

  // A stalled result holds
  `MAA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(decision_o) && $stable(temperature_now_o) && $stable(lowest_energy_o), "stalled result transaction changed")

endmodule

bind metropolis_anneal_accept maa_checker u_maa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .decision_o        (decision_o),
  .new_lowest_o      (new_lowest_o),
  .temperature_now_o (temperature_now_o),
  .lowest_energy_o   (lowest_energy_o)
);
